@@ src/cdp_pkg.sv @@
// Shared types and constants for the complex dot product block.
`timescale 1ns / 1ps

package cdp_pkg;

  localparam int unsigned ACC_WIDTH = 49;
  localparam int unsigned IN_DEPTH  = 2;
  localparam int unsigned OUT_DEPTH = 2;

  typedef struct packed {
    logic last;
    logic herm;
  } cdp_ctrl_t;

endpackage

@@ src/cdp_fifo.sv @@
// Small synchronous word queue used between the block's parts.
`timescale 1ns / 1ps

module cdp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  import cdp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ src/cdp_front.sv @@
// Front end: mode register, word intake and tagging for the work queue.
`timescale 1ns / 1ps

module cdp_front #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  localparam int unsigned WordWidth = $bits(cdp_pkg::cdp_ctrl_t) + 4 * SAMPLE_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  logic signed [SAMPLE_WIDTH-1:0] a_real_i,
  input  logic signed [SAMPLE_WIDTH-1:0] a_imag_i,
  input  logic signed [SAMPLE_WIDTH-1:0] b_real_i,
  input  logic signed [SAMPLE_WIDTH-1:0] b_imag_i,
  input  logic                           last_element_i,
  output logic                           q_push_o,
  output logic [WordWidth-1:0]           q_data_o,
  input  logic                           q_full_i
);
  import cdp_pkg::*;

  logic      conj_q;
  cdp_ctrl_t ctrl;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conj_q <= 1'b1;
    end else if (cfg_valid_i) begin
      conj_q <= cfg_data_i;
    end
  end

  // each word carries the form in force when it arrives
  always_comb begin
    ctrl.last = last_element_i;
    ctrl.herm = conj_q;
  end

  assign q_push_o = push;
  assign q_data_o = {ctrl, a_real_i, a_imag_i, b_real_i, b_imag_i};
  assign full     = q_full_i;

endmodule

@@ src/cdp_back.sv @@
// Back end: product stage, term stage and saturating accumulators.
`timescale 1ns / 1ps

module cdp_back #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  localparam int unsigned WordWidth = $bits(cdp_pkg::cdp_ctrl_t) + 4 * SAMPLE_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_valid_i,
  input  logic [WordWidth-1:0]             q_data_i,
  output logic                             q_pop_o,
  output logic                             res_push_o,
  output logic [2*cdp_pkg::ACC_WIDTH-1:0]  res_data_o,
  input  logic                             res_full_i
);
  import cdp_pkg::*;

  localparam int unsigned PW   = 2 * SAMPLE_WIDTH;
  localparam int unsigned TW   = PW + 1;
  localparam int unsigned KW   = ACC_WIDTH + 3;
  localparam int unsigned LW   = (TW > KW) ? TW : KW;
  localparam int unsigned SW   = ACC_WIDTH + 4;

  localparam logic signed [LW-1:0] TermMax =
      {{(LW - ACC_WIDTH - 2){1'b0}}, 1'b1, {(ACC_WIDTH + 1){1'b0}}};
  localparam logic signed [LW-1:0] TermMin = -TermMax;
  localparam logic signed [SW-1:0] AccMax  =
      {{(SW - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
  localparam logic signed [SW-1:0] AccMin  = -AccMax - SW'(1);

  cdp_ctrl_t                       q_ctrl;
  logic signed [SAMPLE_WIDTH-1:0]  ar, ai, br, bi;
  logic                            en;

  logic                            s1_valid_q;
  cdp_ctrl_t                       s1_ctrl_q;
  logic signed [PW-1:0]            rr_q, ii_q, ri_q, ir_q;

  logic                            s2_valid_q;
  cdp_ctrl_t                       s2_ctrl_q;
  logic signed [KW-1:0]            tr_q, ti_q;
  logic signed [TW-1:0]            tr_full, ti_full;
  logic signed [LW-1:0]            tr_ext, ti_ext;
  logic signed [KW-1:0]            tr_d, ti_d;

  logic signed [ACC_WIDTH-1:0]     real_sum_q, imag_sum_q;
  logic signed [SW-1:0]            real_raw, imag_raw;
  logic signed [ACC_WIDTH-1:0]     real_sat, imag_sat;

  assign {q_ctrl, ar, ai, br, bi} = q_data_i;

  assign en      = !(s2_valid_q && s2_ctrl_q.last && res_full_i);
  assign q_pop_o = en && q_valid_i;

  // product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ctrl_q <= q_ctrl;
      rr_q      <= ar * br;
      ii_q      <= ai * bi;
      ri_q      <= ar * bi;
      ir_q      <= ai * br;
    end
  end

  // term stage: conj(a)*b adds ii and subtracts ir, a*b the reverse
  always_comb begin
    tr_full = s1_ctrl_q.herm ? TW'(rr_q) + TW'(ii_q) : TW'(rr_q) - TW'(ii_q);
    ti_full = s1_ctrl_q.herm ? TW'(ri_q) - TW'(ir_q) : TW'(ri_q) + TW'(ir_q);
    tr_ext  = LW'(tr_full);
    ti_ext  = LW'(ti_full);
    if (tr_ext > TermMax) begin
      tr_d = KW'(TermMax);
    end else if (tr_ext < TermMin) begin
      tr_d = KW'(TermMin);
    end else begin
      tr_d = KW'(tr_ext);
    end
    if (ti_ext > TermMax) begin
      ti_d = KW'(TermMax);
    end else if (ti_ext < TermMin) begin
      ti_d = KW'(TermMin);
    end else begin
      ti_d = KW'(ti_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_ctrl_q <= s1_ctrl_q;
      tr_q      <= tr_d;
      ti_q      <= ti_d;
    end
  end

  // accumulate with saturation to the sum width
  always_comb begin
    real_raw = SW'(real_sum_q) + SW'(tr_q);
    imag_raw = SW'(imag_sum_q) + SW'(ti_q);
    if (real_raw > AccMax) begin
      real_sat = ACC_WIDTH'(AccMax);
    end else if (real_raw < AccMin) begin
      real_sat = ACC_WIDTH'(AccMin);
    end else begin
      real_sat = ACC_WIDTH'(real_raw);
    end
    if (imag_raw > AccMax) begin
      imag_sat = ACC_WIDTH'(AccMax);
    end else if (imag_raw < AccMin) begin
      imag_sat = ACC_WIDTH'(AccMin);
    end else begin
      imag_sat = ACC_WIDTH'(imag_raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      real_sum_q <= '0;
      imag_sum_q <= '0;
    end else if (en && s2_valid_q) begin
      if (s2_ctrl_q.last) begin
        real_sum_q <= '0;
        imag_sum_q <= '0;
      end else begin
        real_sum_q <= real_sat;
        imag_sum_q <= imag_sat;
      end
    end
  end

  assign res_push_o = en && s2_valid_q && s2_ctrl_q.last;
  assign res_data_o = {real_sat, imag_sat};

endmodule

@@ src/complex_dot_product.sv @@
// Top level: streaming complex dot product, Hermitian or bilinear form.
// Path: work queue, product stage, term stage, 49-bit saturating sums, result queue.
// Throughput: one word per cycle while no result waits on a full result queue.
// Reset: sums clear to zero, form resets to Hermitian, both queues empty.
`timescale 1ns / 1ps

module complex_dot_product #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic                                  cfg_data_i,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [SAMPLE_WIDTH-1:0]        a_real_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        a_imag_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        b_real_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        b_imag_i,
  input  logic                                  last_element_i,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [cdp_pkg::ACC_WIDTH-1:0]  dot_real_o,
  output logic signed [cdp_pkg::ACC_WIDTH-1:0]  dot_imag_o
);
  import cdp_pkg::*;

  localparam int unsigned WordWidth = $bits(cdp_ctrl_t) + 4 * SAMPLE_WIDTH;

  logic                       q_push, q_full, q_empty, q_pop;
  logic [WordWidth-1:0]       q_wdata, q_rdata;
  logic                       res_push, res_full;
  logic [2*ACC_WIDTH-1:0]     res_wdata, res_rdata;

  cdp_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i,
    .push,
    .full,
    .a_real_i,
    .a_imag_i,
    .b_real_i,
    .b_imag_i,
    .last_element_i,
    .q_push_o (q_push),
    .q_data_o (q_wdata),
    .q_full_i (q_full)
  );

  cdp_fifo #(
    .Width(WordWidth),
    .Depth(IN_DEPTH)
  ) u_work_q (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  cdp_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i  (!q_empty),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .res_push_o (res_push),
    .res_data_o (res_wdata),
    .res_full_i (res_full)
  );

  cdp_fifo #(
    .Width(2 * ACC_WIDTH),
    .Depth(OUT_DEPTH)
  ) u_res_q (
    .clk_i,
    .rst_ni,
    .push_i  (res_push),
    .data_i  (res_wdata),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_rdata),
    .empty_o (empty)
  );

  assign {dot_real_o, dot_imag_o} = res_rdata;

  a_no_res_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_push && res_full))
    else $error("result word pushed into a full result queue");

  a_pop_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("back end popped an empty work queue");

  a_full_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !q_empty)
    else $error("input reported full with an empty work queue");

endmodule
